### src/esd_pkg.sv
// Shared types, character codes and helpers for the escape sequence decoder.
// No dependencies.
package esd_pkg;

    // decode modes
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_HEX1 = 2'd2;
    localparam logic [1:0] MODE_HEX2 = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    // control codes they decode to
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_HT  = 8'h09;

    // decoder state carried between beats
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] hex_accum;
        logic       hex_stopped;
    } dec_state_t;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_output;
    } dec_result_t;

    // hex digit check and value
    function automatic logic hex_is_digit(input logic [7:0] c);
        hex_is_digit = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
                    || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h61)
            d = c - 8'h57;
        else
            d = c - 8'h37;
        hex_digit = d[3:0];
    endfunction

endpackage

### src/esd_decode.sv
// Per-beat decode logic: next decoder state and result for one byte.
// Depends on esd_pkg.
module esd_decode (
    input  esd_pkg::dec_state_t  cur,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_input,
    output esd_pkg::dec_state_t  nxt,
    output esd_pkg::dec_result_t res
);
    import esd_pkg::*;

    logic       stop_now;
    logic [7:0] accum_upd;
    logic       stopped_upd;

    // hex digit gathering, shared by both hex modes
    assign stop_now    = cur.hex_stopped || !hex_is_digit(in_byte);
    assign accum_upd   = stop_now ? cur.hex_accum : {cur.hex_accum[3:0], hex_digit(in_byte)};
    assign stopped_upd = stop_now;

    always_comb
    begin
        dec_state_t st;
        logic [7:0] val;
        logic       vld;
        st  = cur;
        val = 8'h00;
        vld = 1'b0;
        unique case (cur.mode)
            MODE_TEXT:
            begin
                if (in_byte == CH_BSLASH)
                    st.mode = MODE_ESC;
                else
                begin
                    val = in_byte;
                    vld = 1'b1;
                end
            end
            MODE_ESC:
            begin
                st.mode = MODE_TEXT;
                vld     = 1'b1;
                unique case (in_byte)
                    CH_A:    val = CODE_BEL;
                    CH_B:    val = CODE_BS;
                    CH_F:    val = CODE_FF;
                    CH_N:    val = CODE_LF;
                    CH_R:    val = CODE_CR;
                    CH_T:    val = CODE_HT;
                    CH_X:
                    begin
                        st.mode        = MODE_HEX1;
                        st.hex_accum   = 8'h00;
                        st.hex_stopped = 1'b0;
                        // cut-short escape emits zero
                        vld            = end_of_input;
                    end
                    default: val = in_byte;
                endcase
            end
            MODE_HEX1:
            begin
                st.mode        = MODE_HEX2;
                st.hex_accum   = accum_upd;
                st.hex_stopped = stopped_upd;
                vld            = end_of_input;
                val            = end_of_input ? accum_upd : 8'h00;
            end
            MODE_HEX2:
            begin
                st.mode        = MODE_TEXT;
                st.hex_accum   = accum_upd;
                st.hex_stopped = stopped_upd;
                vld            = 1'b1;
                val            = accum_upd;
            end
            default:
            begin
                st = cur;
            end
        endcase
        // end of string restarts the decoder
        if (end_of_input)
        begin
            st.mode        = MODE_TEXT;
            st.hex_accum   = 8'h00;
            st.hex_stopped = 1'b0;
        end
        nxt               = st;
        res.out_byte      = val;
        res.byte_valid    = vld;
        res.end_of_output = end_of_input;
    end

endmodule

### src/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: input register, decode state,
// result register and stream handshakes. Depends on esd_pkg and esd_decode.
//
// Usage:
//   The slave stream carries raw string bytes, one per beat, with tlast on
//   the final byte of a string. The master stream returns exactly one beat
//   per input beat: tdata is the decoded byte, tuser says whether it holds
//   a character (0 for swallowed backslash, x and first hex byte), tlast
//   copies the input's end mark.
//   A beat in the input register is decoded into the result register when
//   that register is free, and shows on the master side from then on.
//   Throughput is one byte per cycle while the receiver does not stall, set
//   by the single decode stage between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register, if empty, still takes one more beat; after that s_axis_tready
//   drops until the result moves on. Nothing is dropped or repeated.
//   Reset empties both registers and returns the decoder to text mode.
//   After each tlast beat the decoder also returns to text mode, so the
//   next byte starts a new string.
module escape_sequence_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast    // end_of_output
);
    import esd_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;
    logic        s1_adv;

    logic        out_valid_reg;
    dec_result_t out_reg;

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res_next;

    // pipeline control
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_data_reg <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
        end
    end

    // decode stage
    esd_decode u_decode (
        .cur          (state_reg),
        .in_byte      (s1_data_reg),
        .end_of_input (s1_last_reg),
        .nxt          (state_next),
        .res          (res_next)
    );

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode        <= MODE_TEXT;
            state_reg.hex_accum   <= 8'h00;
            state_reg.hex_stopped <= 1'b0;
        end
        else if (s1_adv)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || m_axis_tready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.out_byte;
    assign m_axis_tuser  = out_reg.byte_valid;
    assign m_axis_tlast  = out_reg.end_of_output;

    // checks
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> state_reg.mode == MODE_TEXT && !state_reg.hex_stopped
            && state_reg.hex_accum == 8'h00)
        else $error("decoder did not restart after end of string");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'h00)
        else $error("swallowed beat carries nonzero data");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_data_reg)
            && $stable(s1_last_reg))
        else $error("input register lost a stalled beat");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(state_reg))
        else $error("decoder state changed without a beat");

endmodule

### sim/esd_checker.sv
// Result checker for the escape sequence decoder: watches both streams,
// predicts each decoded beat and compares it with what the block returns.
// Depends on esd_pkg.
`timescale 1ns / 1ps

module esd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_input
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic       m_axis_tuser,   // [0] byte_valid
    input  logic       m_axis_tlast,   // end_of_output
    output int         fail_count,
    output int         pending_count
);
    import esd_pkg::*;

    dec_state_t  dec_st;
    dec_result_t decoded_q[$];

    // digit value in the low nibble, bit 4 set when c is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30;
            return {1'b0, d[3:0]};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d = c - 8'h61 + 8'd10;
            return {1'b0, d[3:0]};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d = c - 8'h41 + 8'd10;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    // fold one byte of a hex escape into the gathered value
    function automatic void absorb_hex(input logic [7:0] c);
        logic [4:0] nib;
        nib = hex_nibble(c);
        if (dec_st.hex_stopped || nib[4])
            dec_st.hex_stopped = 1'b1;
        else
            dec_st.hex_accum = {dec_st.hex_accum[3:0], nib[3:0]};
    endfunction

    // decode one input beat, advancing the predicted state
    function automatic dec_result_t decode_step(input logic [7:0] c, input logic fin);
        dec_result_t r;
        r = '0;
        r.end_of_output = fin;
        case (dec_st.mode)
            MODE_TEXT:
            begin
                if (c == CH_BSLASH)
                    dec_st.mode = MODE_ESC;
                else
                begin
                    r.out_byte   = c;
                    r.byte_valid = 1'b1;
                end
            end
            MODE_ESC:
            begin
                dec_st.mode  = MODE_TEXT;
                r.byte_valid = 1'b1;
                case (c)
                    CH_A:    r.out_byte = CODE_BEL;
                    CH_B:    r.out_byte = CODE_BS;
                    CH_F:    r.out_byte = CODE_FF;
                    CH_N:    r.out_byte = CODE_LF;
                    CH_R:    r.out_byte = CODE_CR;
                    CH_T:    r.out_byte = CODE_HT;
                    CH_X:
                    begin
                        dec_st.mode        = MODE_HEX1;
                        dec_st.hex_accum   = '0;
                        dec_st.hex_stopped = 1'b0;
                        // cut short right after the x: emit zero
                        r.byte_valid       = fin;
                    end
                    default: r.out_byte = c;
                endcase
            end
            MODE_HEX1:
            begin
                absorb_hex(c);
                dec_st.mode = MODE_HEX2;
                if (fin)
                begin
                    r.out_byte   = dec_st.hex_accum;
                    r.byte_valid = 1'b1;
                end
            end
            default:
            begin
                absorb_hex(c);
                r.out_byte   = dec_st.hex_accum;
                r.byte_valid = 1'b1;
                dec_st.mode  = MODE_TEXT;
            end
        endcase
        // end of string: next byte starts fresh
        if (fin)
        begin
            dec_st.mode        = MODE_TEXT;
            dec_st.hex_accum   = '0;
            dec_st.hex_stopped = 1'b0;
        end
        return r;
    endfunction

    // compare the returned beat first, then queue the prediction for the new input
    always @(posedge clk or negedge rst_n)
    begin
        dec_result_t exp_r;
        if (!rst_n)
        begin
            dec_st.mode        = MODE_TEXT;
            dec_st.hex_accum   = '0;
            dec_st.hex_stopped = 1'b0;
            decoded_q.delete();
            fail_count         = 0;
            pending_count      = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected beat expected none actual %02h/%0b/%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_r = decoded_q.pop_front();
                    if (m_axis_tdata !== exp_r.out_byte)
                    begin
                        $display("%0t: out_byte mismatch expected %02h actual %02h",
                                 $time, exp_r.out_byte, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== exp_r.byte_valid)
                    begin
                        $display("%0t: byte_valid mismatch expected %0b actual %0b",
                                 $time, exp_r.byte_valid, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tlast !== exp_r.end_of_output)
                    begin
                        $display("%0t: end_of_output mismatch expected %0b actual %0b",
                                 $time, exp_r.end_of_output, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decoded_q.push_back(decode_step(s_axis_tdata, s_axis_tlast));
            pending_count = decoded_q.size();
        end
    end

endmodule

### sim/tb_escape_sequence_decoder.sv
// Testbench top for the escape sequence decoder: clock, reset, string stimulus
// with random gaps and receiver stalls, and the final verdict.
// Depends on esd_pkg, escape_sequence_decoder and esd_checker.
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;
    import esd_pkg::*;

    localparam int IDLE_PCT   = 37;
    localparam int CALM_START = 300;    // no idling on either side in this window
    localparam int CALM_END   = 800;
    localparam int HOLD_START = 1200;   // receiver holds off in this window
    localparam int HOLD_END   = 1500;
    localparam int RANDOM_ITEMS = 1700;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       s_axis_tlast;    // end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tuser;    // [0] byte_valid
    logic       m_axis_tlast;    // end_of_output

    int         fail_count;
    int         pending_count;

    logic [7:0] str_byte_q[$];
    logic       str_last_q[$];

    escape_sequence_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    esd_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #3_600_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_byte(input logic [7:0] b, input logic fin);
        str_byte_q.push_back(b);
        str_last_q.push_back(fin);
    endtask

    // random character among 0-9, a-f, A-F
    function automatic logic [7:0] rand_hex_char();
        int n;
        n = $urandom_range(0, 21);
        if (n < 10)
            return 8'(8'h30 + n);
        else if (n < 16)
            return 8'(8'h61 + n - 10);
        return 8'(8'h41 + n - 16);
    endfunction

    function automatic logic [7:0] rand_escape_letter();
        case ($urandom_range(0, 5))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_F;
            3:       return CH_N;
            4:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // build the string stream: directed cases, then random strings
    task automatic build_strings();
        logic [7:0] one_str[$];
        logic [7:0] b;
        int         n_tok;
        int         cut;
        int         pick;
        // plain extremes
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // every control escape
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_A, 1'b0);
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_B, 1'b0);
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_F, 1'b0);
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_N, 1'b0);
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_R, 1'b0);
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_T, 1'b0);
        // full hex escape, lower and upper case digits
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_X, 1'b0);
        push_byte(8'h61, 1'b0);     push_byte(8'h46, 1'b0);
        // non-hex first byte stops gathering, the digit after it is ignored
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_X, 1'b0);
        push_byte(8'h47, 1'b0);     push_byte(8'h37, 1'b0);
        // escaped backslash passes through
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_BSLASH, 1'b1);
        // trailing backslash
        push_byte(CH_BSLASH, 1'b1);
        // hex escape cut right after the x
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_X, 1'b1);
        // hex escape cut after one digit
        push_byte(CH_BSLASH, 1'b0); push_byte(CH_X, 1'b0); push_byte(8'h39, 1'b1);

        while (str_byte_q.size() < RANDOM_ITEMS + 30)
        begin
            one_str.delete();
            n_tok = $urandom_range(1, 12);
            for (int t = 0; t < n_tok; t++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_BSLASH)
                        b = 8'h5D;
                    one_str.push_back(b);
                end
                else if (pick < 60)
                begin
                    one_str.push_back(CH_BSLASH);
                    one_str.push_back(rand_escape_letter());
                end
                else if (pick < 80)
                begin
                    one_str.push_back(CH_BSLASH);
                    one_str.push_back(CH_X);
                    for (int k = 0; k < 2; k++)
                        one_str.push_back(($urandom_range(0, 99) < 85)
                                          ? rand_hex_char() : 8'($urandom_range(0, 255)));
                end
                else if (pick < 90)
                begin
                    one_str.push_back(CH_BSLASH);
                    one_str.push_back(8'($urandom_range(0, 255)));
                end
                else
                    one_str.push_back(8'($urandom_range(0, 255)));
            end
            // sometimes cut the string short, which can end it in the middle of an escape
            cut = one_str.size();
            if ($urandom_range(0, 99) < 20)
                cut = $urandom_range(1, one_str.size());
            for (int i = 0; i < cut; i++)
                push_byte(one_str[i], i == cut - 1);
        end
    endtask

    // receiver: random stalls, one long hold-off, a calm window
    initial
    begin
        int cyc;
        cyc           = 0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_END)
                m_axis_tready <= 1'b0;
            else if (cyc >= CALM_START && cyc < CALM_END)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // reset, sender, end of run
    initial
    begin
        int idx;
        int cyc;
        int n_items;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        build_strings();
        n_items = str_byte_q.size();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        idx = 0;
        cyc = 0;
        while (idx < n_items)
        begin
            @(posedge clk);
            cyc++;
            if (s_axis_tvalid && s_axis_tready)
                idx++;
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // beat still waiting: keep it on the bus
            end
            else if (idx < n_items &&
                     ((cyc >= CALM_START && cyc < CALM_END) ||
                      $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= str_byte_q[idx];
                s_axis_tlast  <= str_last_q[idx];
            end
            else
                s_axis_tvalid <= 1'b0;
        end

        // let the checker count the last beat, drain, then wait for anything stray
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
